// ===== rtl/lrr_pkg.sv =====
// Shared types and constants of the LIN response receiver.
`default_nettype none

package lrr_pkg;

    localparam int RAW_DEPTH   = 48;
    localparam int MAX_DATA    = 8;
    localparam int QUEUE_DEPTH = 2;

    localparam int DATA_IDX_W = (MAX_DATA > 1) ? $clog2(MAX_DATA) : 1;
    localparam int SCNT_W     = $clog2(RAW_DEPTH + 1);

    localparam logic [7:0] SYNC_BYTE     = 8'h55;
    localparam logic [5:0] CLASSIC_FIRST = 6'h3C;

    typedef enum logic [1:0] {
        ACT_START   = 2'd0,
        ACT_BYTE    = 2'd1,
        ACT_GAP     = 2'd2,
        ACT_TIMEOUT = 2'd3
    } action_t;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_CHK_ERR   = 3'd1,
        ST_TRUNC     = 3'd2,
        ST_NO_RESP   = 3'd3,
        ST_NOT_REQ   = 3'd4,
        ST_STARTED   = 3'd5
    } status_t;

    // One queued command: either a single status word or a burst of data words.
    typedef struct packed {
        status_t                     status;
        logic [7:0]                  pid;
        logic                        has_data;
        logic                        last;
        logic [3:0]                  len;
        logic [MAX_DATA-1:0][7:0]    data;
    } cmd_t;

    typedef struct packed {
        status_t    status;
        logic [7:0] pid;
        logic [7:0] data;
        logic [2:0] idx;
        logic       has_data;
        logic       last;
    } res_t;

endpackage

`default_nettype wire

// ===== rtl/lrr_front.sv =====
// Front end: frame tracking, header search, data capture and checksum.
`default_nettype none

module lrr_front (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          accept,
    input  wire logic [1:0]    action,
    input  wire logic [5:0]    frame_id,
    input  wire logic [3:0]    expected_len,
    input  wire logic [7:0]    rx_byte,
    output logic               push,
    output lrr_pkg::cmd_t      cmd
);
    import lrr_pkg::*;

    function automatic logic [7:0] make_pid(input logic [5:0] id);
        logic p0;
        logic p1;
        p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
        p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
        return {p1, p0, id};
    endfunction

    function automatic logic [7:0] add_carry(input logic [7:0] s, input logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, s} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

    logic                     active_reg, active_next;
    logic                     header_seen_reg, header_seen_next;
    logic [7:0]               pid_reg, pid_next;
    logic [3:0]               len_reg, len_next;
    logic [7:0]               prev_byte_reg, prev_byte_next;
    logic [SCNT_W-1:0]        stored_count_reg, stored_count_next;
    logic [3:0]               after_header_count_reg, after_header_count_next;
    logic [7:0]               running_sum_reg, running_sum_next;
    logic [MAX_DATA-1:0][7:0] data_store_reg;

    logic                     store_we;
    logic [DATA_IDX_W-1:0]    store_idx;
    logic [3:0]               len_sat;
    logic [7:0]               pid_new;
    logic [3:0]               ahc_inc;

    always_comb
    begin
        active_next             = active_reg;
        header_seen_next        = header_seen_reg;
        pid_next                = pid_reg;
        len_next                = len_reg;
        prev_byte_next          = prev_byte_reg;
        stored_count_next       = stored_count_reg;
        after_header_count_next = after_header_count_reg;
        running_sum_next        = running_sum_reg;
        store_we                = 1'b0;
        store_idx               = after_header_count_reg[DATA_IDX_W-1:0];
        push                    = 1'b0;
        len_sat   = (expected_len > 4'(MAX_DATA)) ? 4'(MAX_DATA) : expected_len;
        pid_new   = make_pid(frame_id);
        ahc_inc   = after_header_count_reg + 4'd1;

        cmd.status   = ST_STARTED;
        cmd.pid      = pid_reg;
        cmd.has_data = 1'b0;
        cmd.last     = 1'b1;
        cmd.len      = len_reg;
        cmd.data     = data_store_reg;

        if (accept)
        begin
            unique case (action_t'(action))
                ACT_START:
                begin
                    pid_next                = pid_new;
                    len_next                = len_sat;
                    header_seen_next        = 1'b0;
                    prev_byte_next          = 8'd0;
                    stored_count_next       = '0;
                    after_header_count_next = 4'd0;
                    running_sum_next = (pid_new[5:0] >= CLASSIC_FIRST) ? 8'd0 : pid_new;
                    push    = 1'b1;
                    cmd.pid = pid_new;
                    if (len_sat == 4'd0)
                    begin
                        active_next = 1'b0;
                        cmd.status  = ST_NOT_REQ;
                    end
                    else
                    begin
                        active_next = 1'b1;
                        cmd.last    = 1'b0;
                    end
                end
                ACT_BYTE:
                begin
                    if (active_reg && stored_count_reg < SCNT_W'(RAW_DEPTH))
                    begin
                        stored_count_next = stored_count_reg + SCNT_W'(1);
                        prev_byte_next    = rx_byte;
                        if (!header_seen_reg)
                        begin
                            if (stored_count_reg != '0 && prev_byte_reg == SYNC_BYTE &&
                                rx_byte == pid_reg)
                            begin
                                header_seen_next        = 1'b1;
                                after_header_count_next = 4'd0;
                            end
                        end
                        else
                        begin
                            after_header_count_next = ahc_inc;
                            if (ahc_inc <= len_reg)
                            begin
                                store_we         = 1'b1;
                                running_sum_next = add_carry(running_sum_reg, rx_byte);
                            end
                            else
                            begin
                                // The checksum byte closes the frame.
                                push         = 1'b1;
                                active_next  = 1'b0;
                                cmd.has_data = 1'b1;
                                cmd.status   = (rx_byte == ~running_sum_reg) ?
                                               ST_OK : ST_CHK_ERR;
                            end
                        end
                    end
                end
                ACT_GAP:
                begin
                    if (active_reg && header_seen_reg && after_header_count_reg != 4'd0)
                    begin
                        push        = 1'b1;
                        active_next = 1'b0;
                        cmd.status  = ST_TRUNC;
                    end
                end
                ACT_TIMEOUT:
                begin
                    if (active_reg)
                    begin
                        push        = 1'b1;
                        active_next = 1'b0;
                        cmd.status  = header_seen_reg ? ST_TRUNC : ST_NO_RESP;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg             <= 1'b0;
            header_seen_reg        <= 1'b0;
            pid_reg                <= 8'd0;
            len_reg                <= 4'd0;
            prev_byte_reg          <= 8'd0;
            stored_count_reg       <= '0;
            after_header_count_reg <= 4'd0;
            running_sum_reg        <= 8'd0;
        end
        else
        begin
            active_reg             <= active_next;
            header_seen_reg        <= header_seen_next;
            pid_reg                <= pid_next;
            len_reg                <= len_next;
            prev_byte_reg          <= prev_byte_next;
            stored_count_reg       <= stored_count_next;
            after_header_count_reg <= after_header_count_next;
            running_sum_reg        <= running_sum_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (store_we)
        begin
            data_store_reg[store_idx] <= rx_byte;
        end
    end

    a_active_len: assert property (@(posedge clk) disable iff (!rst_n)
        active_reg |-> (len_reg != 4'd0 && len_reg <= 4'(MAX_DATA)))
        else $error("active frame with an invalid length");

    a_ahc_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (active_reg && header_seen_reg) |-> after_header_count_reg <= len_reg)
        else $error("data count ran past the frame length");

endmodule

`default_nettype wire

// ===== rtl/lrr_queue.sv =====
// Short command queue between front end and result sequencer.
`default_nettype none

module lrr_queue (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          push,
    input  wire lrr_pkg::cmd_t push_cmd,
    input  wire logic          pop,
    output logic               not_empty,
    output logic               full,
    output lrr_pkg::cmd_t      head
);
    import lrr_pkg::*;

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign not_empty = (count_reg != '0);
    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign head      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 :
                          rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("command pushed into a full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("command popped from an empty queue");

endmodule

`default_nettype wire

// ===== rtl/lrr_back.sv =====
// Result sequencer: expands queued commands into output words.
`default_nettype none

module lrr_back (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          cmd_avail,
    input  wire lrr_pkg::cmd_t head,
    output logic               pop,
    input  wire logic          out_stall,
    output logic               out_valid,
    output lrr_pkg::res_t      res
);
    import lrr_pkg::*;

    logic       valid_reg, valid_next;
    res_t       res_reg, res_next;
    logic [2:0] idx_reg, idx_next;
    logic       load;
    logic       final_word;

    assign out_valid = valid_reg;
    assign res       = res_reg;

    always_comb
    begin
        load       = !valid_reg || !out_stall;
        final_word = head.has_data ? (({1'b0, idx_reg} + 4'd1) == head.len) : 1'b1;
        pop        = 1'b0;
        idx_next   = idx_reg;
        res_next   = res_reg;
        valid_next = valid_reg;

        if (load)
        begin
            valid_next = cmd_avail;
            if (cmd_avail)
            begin
                res_next.status   = head.status;
                res_next.pid      = head.pid;
                res_next.has_data = head.has_data;
                if (head.has_data)
                begin
                    res_next.data = head.data[idx_reg[DATA_IDX_W-1:0]];
                    res_next.idx  = idx_reg;
                    res_next.last = final_word;
                end
                else
                begin
                    res_next.data = 8'd0;
                    res_next.idx  = 3'd0;
                    res_next.last = head.last;
                end
                if (final_word)
                begin
                    pop      = 1'b1;
                    idx_next = 3'd0;
                end
                else
                begin
                    idx_next = idx_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            idx_reg   <= 3'd0;
        end
        else
        begin
            valid_reg <= valid_next;
            idx_reg   <= idx_next;
        end
    end

    always_ff @(posedge clk)
    begin
        res_reg <= res_next;
    end

    a_burst_holds_head: assert property (@(posedge clk) disable iff (!rst_n)
        (idx_reg != 3'd0) |-> (cmd_avail && head.has_data &&
                               ({1'b0, idx_reg} < head.len)))
        else $error("burst position without a matching data command");

    a_last_pops: assert property (@(posedge clk) disable iff (!rst_n)
        (load && cmd_avail && final_word) |=> (idx_reg == 3'd0))
        else $error("burst position not cleared after the final word");

endmodule

`default_nettype wire

// ===== rtl/lin_response_receiver_unit.sv =====
// A word passes through the command queue and then the result register before it reaches the port.
// A completed frame gives one data word per unstalled cycle; a start or an ending gives one word.
// Item and result sides each move one word per cycle; a two-entry command queue lets
// them stall independently, so input stalls only when that queue is full.
// Reset (rst_n, asynchronous, active low) clears all control state; the block comes up idle.
`default_nettype none

module lin_response_receiver_unit (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       item_valid,
    output logic            item_stall,
    input  wire logic [1:0] action,
    input  wire logic [5:0] frame_id,
    input  wire logic [3:0] expected_len,
    input  wire logic [7:0] rx_byte,
    output logic            result_valid,
    input  wire logic       result_stall,
    output logic [2:0]      status,
    output logic [7:0]      protected_id,
    output logic [7:0]      data_byte,
    output logic [2:0]      byte_index,
    output logic            has_data,
    output logic            last
);
    import lrr_pkg::*;

    logic  accept;
    logic  push;
    logic  pop;
    logic  q_not_empty;
    logic  q_full;
    cmd_t  push_cmd;
    cmd_t  head;
    res_t  res;

    assign item_stall = q_full;
    assign accept     = item_valid && !q_full;

    lrr_front u_front (
        .clk          (clk),
        .rst_n        (rst_n),
        .accept       (accept),
        .action       (action),
        .frame_id     (frame_id),
        .expected_len (expected_len),
        .rx_byte      (rx_byte),
        .push         (push),
        .cmd          (push_cmd)
    );

    lrr_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .pop       (pop),
        .not_empty (q_not_empty),
        .full      (q_full),
        .head      (head)
    );

    lrr_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_avail (q_not_empty),
        .head      (head),
        .pop       (pop),
        .out_stall (result_stall),
        .out_valid (result_valid),
        .res       (res)
    );

    assign status       = res.status;
    assign protected_id = res.pid;
    assign data_byte    = res.data;
    assign byte_index   = res.idx;
    assign has_data     = res.has_data;
    assign last         = res.last;

endmodule

`default_nettype wire

// ===== test/tb_top.sv =====
// Self-checking testbench for the LIN response receiver: directed, random and back-pressure runs.
`timescale 1ns / 1ps

module tb_top;
    import lrr_pkg::*;

    localparam int QUIET_LIMIT = 2000;
    localparam int HOLD_CYCLES = 300;
    localparam int DRAIN_WAIT  = 10;

    typedef enum int {
        END_NORMAL,
        END_GAP,
        END_TIMEOUT,
        END_ABANDON
    } frame_end_t;

    logic       clk          = 1'b0;
    logic       rst_n        = 1'b0;
    logic       item_valid   = 1'b0;
    logic       item_stall;
    logic [1:0] action       = ACT_GAP;
    logic [5:0] frame_id     = 6'd0;
    logic [3:0] expected_len = 4'd0;
    logic [7:0] rx_byte      = 8'd0;
    logic       result_valid;
    logic       result_stall = 1'b0;
    logic [2:0] status;
    logic [7:0] protected_id;
    logic [7:0] data_byte;
    logic [2:0] byte_index;
    logic       has_data;
    logic       last;

    int errors         = 0;
    int sent_words     = 0;
    int send_gap_pct   = 0;
    int recv_stall_pct = 0;
    int quiet_cycles   = 0;
    bit hold_request   = 1'b0;

    // Words the block still owes, oldest first.
    res_t due_words[$];

    // Receiver state as the block should hold it.
    bit         rx_active;
    bit         hdr_seen;
    logic [7:0] cur_pid;
    int         cur_len;
    logic [7:0] last_byte;
    int         kept;
    int         data_cnt;
    logic [7:0] sum;
    logic [7:0] frame_data [MAX_DATA];

    lin_response_receiver_unit dut (.*);

    initial
    begin
        forever #10 clk = ~clk;
    end

    function automatic logic [7:0] lin_pid(logic [5:0] id);
        return {~(id[1] ^ id[3] ^ id[4] ^ id[5]), id[0] ^ id[1] ^ id[2] ^ id[4], id};
    endfunction

    function automatic logic [7:0] add_eac(logic [7:0] a, logic [7:0] b);
        logic [8:0] t;
        t = {1'b0, a} + {1'b0, b};
        return t[7:0] + {7'd0, t[8]};
    endfunction

    function automatic void queue_word(status_t st, logic [7:0] d, logic [2:0] idx,
                                       logic has, logic lst);
        res_t w;
        w.status   = st;
        w.pid      = cur_pid;
        w.data     = d;
        w.idx      = idx;
        w.has_data = has;
        w.last     = lst;
        due_words.push_back(w);
    endfunction

    function automatic void follow_item(action_t act, logic [5:0] id, logic [3:0] len,
                                        logic [7:0] b);
        status_t st;
        int i;
        case (act)
            ACT_START:
            begin
                cur_pid   = lin_pid(id);
                cur_len   = (len > MAX_DATA) ? MAX_DATA : len;
                hdr_seen  = 1'b0;
                last_byte = 8'h00;
                kept      = 0;
                data_cnt  = 0;
                sum       = (cur_pid[5:0] >= CLASSIC_FIRST) ? 8'h00 : cur_pid;
                if (cur_len == 0)
                begin
                    rx_active = 1'b0;
                    queue_word(ST_NOT_REQ, 8'h00, 3'd0, 1'b0, 1'b1);
                end
                else
                begin
                    rx_active = 1'b1;
                    queue_word(ST_STARTED, 8'h00, 3'd0, 1'b0, 1'b0);
                end
            end
            ACT_BYTE:
            begin
                if (rx_active && kept < RAW_DEPTH)
                begin
                    kept++;
                    if (!hdr_seen)
                    begin
                        if (kept >= 2 && last_byte == SYNC_BYTE && b == cur_pid)
                        begin
                            hdr_seen = 1'b1;
                            data_cnt = 0;
                        end
                        last_byte = b;
                    end
                    else
                    begin
                        last_byte = b;
                        data_cnt++;
                        if (data_cnt <= cur_len)
                        begin
                            frame_data[data_cnt - 1] = b;
                            sum = add_eac(sum, b);
                        end
                        else
                        begin
                            // Checksum byte: every data word carries the final status.
                            st = (b == ~sum) ? ST_OK : ST_CHK_ERR;
                            for (i = 0; i < cur_len; i++)
                                queue_word(st, frame_data[i], i[2:0], 1'b1, i == cur_len - 1);
                            rx_active = 1'b0;
                        end
                    end
                end
            end
            ACT_GAP:
            begin
                if (rx_active && hdr_seen && data_cnt >= 1)
                begin
                    rx_active = 1'b0;
                    queue_word(ST_TRUNC, 8'h00, 3'd0, 1'b0, 1'b1);
                end
            end
            default:
            begin
                if (rx_active)
                begin
                    rx_active = 1'b0;
                    queue_word(hdr_seen ? ST_TRUNC : ST_NO_RESP, 8'h00, 3'd0, 1'b0, 1'b1);
                end
            end
        endcase
    endfunction

    // Check the result side first, then predict from the item side.
    always @(posedge clk)
    begin
        res_t got;
        res_t want;
        if (rst_n && result_valid && !result_stall)
        begin
            got = {status, protected_id, data_byte, byte_index, has_data, last};
            if (due_words.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected word: status %0d pid %h data %h idx %0d has %b last %b",
                         $time, got.status, got.pid, got.data, got.idx, got.has_data,
                         got.last);
            end
            else
            begin
                want = due_words.pop_front();
                if (got !== want)
                begin
                    errors++;
                    $display("%0t: mismatch: expected status %0d pid %h data %h idx %0d %s",
                             $time, want.status, want.pid, want.data, want.idx,
                             $sformatf("has %b last %b", want.has_data, want.last));
                    $display("%0t:           actual status %0d pid %h data %h idx %0d %s",
                             $time, got.status, got.pid, got.data, got.idx,
                             $sformatf("has %b last %b", got.has_data, got.last));
                end
            end
        end
        if (rst_n && item_valid && !item_stall)
            follow_item(action_t'(action), frame_id, expected_len, rx_byte);
    end

    always @(posedge clk)
    begin
        if ((item_valid && !item_stall) || (result_valid && !result_stall))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    // Result side: random stalls, or one long hold when asked for.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                hold_request = 1'b0;
                result_stall <= 1'b1;
                repeat (HOLD_CYCLES - 1) @(posedge clk);
            end
            else
            begin
                result_stall <= ($urandom_range(99) < recv_stall_pct);
            end
        end
    end

    // Offers one word and returns at the edge that accepts it.
    task automatic send_word(action_t act, logic [5:0] id, logic [3:0] len, logic [7:0] b);
        if ($urandom_range(99) < send_gap_pct)
        begin
            item_valid <= 1'b0;
            repeat ($urandom_range(1, 4)) @(posedge clk);
        end
        item_valid   <= 1'b1;
        action       <= act;
        frame_id     <= (act == ACT_START) ? id : 6'($urandom);
        expected_len <= (act == ACT_START) ? len : 4'($urandom);
        rx_byte      <= (act == ACT_BYTE) ? b : 8'($urandom);
        sent_words++;
        @(posedge clk);
        while (item_stall) @(posedge clk);
    endtask

    task automatic drain;
        item_valid <= 1'b0;
        while (due_words.size() != 0) @(posedge clk);
    endtask

    // One transaction: start, optional noise, header, data, checksum, or an early ending.
    task automatic run_frame(logic [5:0] id, logic [3:0] len_f, int noise_n, bit bad_sync,
                             bit bad_sum, frame_end_t how, int cut_at);
        logic [7:0] pid;
        logic [7:0] csum;
        logic [7:0] b;
        int n;
        int i;
        pid  = lin_pid(id);
        n    = (len_f > MAX_DATA) ? MAX_DATA : len_f;
        csum = (id >= CLASSIC_FIRST) ? 8'h00 : pid;
        send_word(ACT_START, id, len_f, 8'h00);
        if (n == 0)
            return;
        for (i = 0; i < noise_n; i++)
        begin
            do b = 8'($urandom); while (b == SYNC_BYTE);
            send_word(ACT_BYTE, 6'd0, 4'd0, b);
        end
        send_word(ACT_BYTE, 6'd0, 4'd0, SYNC_BYTE);
        send_word(ACT_BYTE, 6'd0, 4'd0, bad_sync ? pid ^ 8'($urandom_range(1, 255)) : pid);
        for (i = 0; i <= n; i++)
        begin
            if (how != END_NORMAL && i == cut_at)
            begin
                // A gap may be ignored, so a timeout follows it to close the frame.
                if (how == END_GAP)
                begin
                    send_word(ACT_GAP, 6'd0, 4'd0, 8'h00);
                    send_word(ACT_TIMEOUT, 6'd0, 4'd0, 8'h00);
                end
                else if (how == END_TIMEOUT)
                begin
                    send_word(ACT_TIMEOUT, 6'd0, 4'd0, 8'h00);
                end
                return;
            end
            if (i < n)
            begin
                b    = 8'($urandom);
                csum = add_eac(csum, b);
            end
            else
            begin
                b = bad_sum ? ~csum ^ 8'($urandom_range(1, 255)) : ~csum;
            end
            send_word(ACT_BYTE, 6'd0, 4'd0, b);
        end
        // Without a header, or with the raw store overrun, the frame cannot finish by itself.
        if (bad_sync || noise_n + n + 3 > RAW_DEPTH)
            send_word(ACT_TIMEOUT, 6'd0, 4'd0, 8'h00);
    endtask

    task automatic test_idle_words;
        send_word(ACT_BYTE, 6'd0, 4'd0, SYNC_BYTE);
        send_word(ACT_GAP, 6'd0, 4'd0, 8'h00);
        send_word(ACT_TIMEOUT, 6'd0, 4'd0, 8'h00);
        drain;
    endtask

    task automatic test_lengths;
        run_frame(6'h00, 4'd0, 0, 1'b0, 1'b0, END_NORMAL, 0);
        // A long length saturates; the frame is dropped by the next start.
        run_frame(6'h3F, 4'd15, 0, 1'b0, 1'b0, END_ABANDON, 0);
        run_frame(6'h3C, 4'd1, 0, 1'b0, 1'b0, END_NORMAL, 0);
        drain;
    endtask

    task automatic test_checksum;
        run_frame(6'h15, 4'd2, 1, 1'b0, 1'b1, END_NORMAL, 0);
        drain;
    endtask

    task automatic test_endings;
        send_word(ACT_START, 6'h2A, 4'd2, 8'h00);
        send_word(ACT_GAP, 6'd0, 4'd0, 8'h00);
        send_word(ACT_TIMEOUT, 6'd0, 4'd0, 8'h00);
        run_frame(6'h11, 4'd3, 0, 1'b0, 1'b0, END_GAP, 0);
        run_frame(6'h22, 4'd3, 0, 1'b0, 1'b0, END_GAP, 2);
        run_frame(6'h07, 4'd4, 0, 1'b0, 1'b0, END_TIMEOUT, 0);
        drain;
    endtask

    task automatic test_random(int n);
        int first;
        int skipped;
        int r;
        int len_r;
        int noise_n;
        int cut_at;
        logic [5:0] id;
        frame_end_t how;
        first   = sent_words;
        skipped = 0;
        while (sent_words - first - skipped < n)
        begin
            id = ($urandom_range(99) < 15) ? 6'($urandom_range(60, 63)) : 6'($urandom);
            r  = $urandom_range(99);
            if (r < 5)
                len_r = 0;
            else if (r < 15)
                len_r = $urandom_range(9, 15);
            else if (r < 40)
                len_r = $urandom_range(1, 2);
            else
                len_r = $urandom_range(1, 8);
            noise_n = ($urandom_range(99) < 5) ? $urandom_range(44, 52) : $urandom_range(0, 2);
            r = $urandom_range(99);
            if (r < 10)
                how = END_GAP;
            else if (r < 17)
                how = END_TIMEOUT;
            else if (r < 20)
                how = END_ABANDON;
            else
                how = END_NORMAL;
            cut_at = $urandom_range(0, (len_r > MAX_DATA) ? MAX_DATA : len_r);
            run_frame(id, 4'(len_r), noise_n, $urandom_range(99) < 8, $urandom_range(99) < 15,
                      how, cut_at);
            if ($urandom_range(99) < 20)
            begin
                send_word(action_t'($urandom_range(1, 3)), 6'd0, 4'd0, 8'($urandom));
                skipped++;
            end
        end
        drain;
    endtask

    task automatic test_backpressure;
        int i;
        hold_request = 1'b1;
        for (i = 0; i < 3; i++)
            run_frame(6'($urandom), 4'd8, 0, 1'b0, 1'b0, END_NORMAL, 0);
        drain;
    endtask

    initial
    begin
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_gap_pct   = 30;
        recv_stall_pct = 45;
        test_idle_words;
        test_lengths;
        test_checksum;
        test_endings;
        test_random(55);

        send_gap_pct   = 45;
        recv_stall_pct = 30;
        test_random(55);

        send_gap_pct   = 0;
        recv_stall_pct = 0;
        test_backpressure;
        test_random(55);

        drain;
        repeat (DRAIN_WAIT) @(posedge clk);
        if (errors == 0 && due_words.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule
